/* hdl/dnle_pkg.sv */
`timescale 1ns / 1ps
package dnle_pkg;

	localparam logic OP_CHAR   = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [7:0] DOT_CHAR = 8'd46;

	typedef struct packed {
		logic       op;
		logic [7:0] char_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [1:0] pair_count;
		logic       error_flag;
		logic       run_end;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic store_wr;
		logic ovf_set;
		logic ovf_clr;
		logic len_clr;
		logic flush_start;
		logic k_inc;
		logic cap_first;
		logic cap_second;
		logic load_err;
		logic load_pair;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_finish;
		logic is_dot;
		logic len_full;
		logic ovf;
		logic more;
		logic out_free;
	} ctrl_sts_t;

endpackage

/* hdl/dnle_datapath.sv */
`timescale 1ns / 1ps
module dnle_datapath #(
	parameter int MAX_LABEL = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dnle_pkg::req_t     req_data,
	input  dnle_pkg::ctrl_cmd_t cmd,
	output dnle_pkg::ctrl_sts_t sts,
	input  logic               rsp_ready,
	output logic               rsp_valid,
	output dnle_pkg::rsp_t     rsp_data
);
	import dnle_pkg::*;

	localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
	localparam int LW = $clog2(MAX_LABEL + 1);
	localparam int KW = $clog2(MAX_LABEL + 3);

	localparam logic [1:0] SRC_LEN  = 2'd0;
	localparam logic [1:0] SRC_MEM  = 2'd1;
	localparam logic [1:0] SRC_ZERO = 2'd2;

	logic [7:0]    mem_q [MAX_LABEL];
	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] total_q;
	logic [7:0]    rdata_q;
	logic [1:0]    src_q;
	logic [7:0]    first_q;
	logic [7:0]    second_q;
	logic          two_q;
	logic          rsp_valid_q;
	rsp_t          rsp_data_q;

	logic [AW-1:0] rd_addr;
	logic [1:0]    src_next;
	logic [7:0]    byte_val;
	logic [KW-1:0] len_ext;
	logic          fin_extra;

	assign len_ext   = KW'(len_q);
	assign rd_addr   = AW'(k_q - KW'(1));
	assign fin_extra = (req_data.op == OP_FINISH) && (len_q != '0);

	always_comb begin
		if (k_q == '0) begin
			src_next = SRC_LEN;
		end else if (k_q <= len_ext) begin
			src_next = SRC_MEM;
		end else begin
			src_next = SRC_ZERO;
		end
	end

	always_comb begin
		unique case (src_q)
			SRC_LEN: byte_val = 8'(len_q);
			SRC_MEM: byte_val = rdata_q;
			default: byte_val = 8'd0;
		endcase
	end

	// label store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store_wr) begin
			mem_q[AW'(len_q)] <= req_data.char_byte;
		end
		rdata_q <= mem_q[rd_addr];
		src_q   <= src_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ovf_q   <= 1'b0;
			k_q     <= '0;
			total_q <= '0;
		end else begin
			if (cmd.len_clr) begin
				len_q <= '0;
			end else if (cmd.store_wr) begin
				len_q <= len_q + LW'(1);
			end
			if (cmd.ovf_clr) begin
				ovf_q <= 1'b0;
			end else if (cmd.ovf_set) begin
				ovf_q <= 1'b1;
			end
			if (cmd.flush_start) begin
				k_q     <= '0;
				total_q <= len_ext + KW'(1) + KW'(fin_extra);
			end else if (cmd.k_inc) begin
				k_q <= k_q + KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_first) begin
			first_q  <= byte_val;
			second_q <= 8'd0;
			two_q    <= 1'b0;
		end else if (cmd.cap_second) begin
			second_q <= byte_val;
			two_q    <= 1'b1;
		end
	end

	// output register parts the result side from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_err || cmd.load_pair) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			rsp_data_q.first_byte  <= 8'd0;
			rsp_data_q.second_byte <= 8'd0;
			rsp_data_q.pair_count  <= 2'd1;
			rsp_data_q.error_flag  <= 1'b1;
			rsp_data_q.run_end     <= 1'b1;
		end else if (cmd.load_pair) begin
			rsp_data_q.first_byte  <= first_q;
			rsp_data_q.second_byte <= second_q;
			rsp_data_q.pair_count  <= two_q ? 2'd2 : 2'd1;
			rsp_data_q.error_flag  <= 1'b0;
			rsp_data_q.run_end     <= (k_q == total_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	assign sts.is_finish = (req_data.op == OP_FINISH);
	assign sts.is_dot    = (req_data.char_byte == DOT_CHAR);
	assign sts.len_full  = (len_q == LW'(MAX_LABEL));
	assign sts.ovf       = ovf_q;
	assign sts.more      = (k_q != total_q);
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_LABEL))
		else $error("label length past limit");
	a_no_store_after_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_wr |-> !ovf_q && !sts.len_full)
		else $error("character stored while label is full or rejected");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_err || cmd.load_pair) |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten before transfer");
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_err |=> rsp_valid_q && rsp_data_q.run_end && rsp_data_q.pair_count == 2'd1)
		else $error("error result malformed");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= total_q)
		else $error("byte index ran past end of flush");
`endif

endmodule

/* hdl/dnle_ctrl.sv */
`timescale 1ns / 1ps
module dnle_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  dnle_pkg::ctrl_sts_t sts,
	output dnle_pkg::ctrl_cmd_t cmd
);
	import dnle_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_CAP_A = 3'd2;
	localparam logic [2:0] ST_CAP_B = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign req_ready = (state_q == ST_IDLE) && sts.out_free;
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (sts.is_finish) begin
						if (sts.ovf) begin
							cmd.ovf_clr = 1'b1;
							cmd.len_clr = 1'b1;
						end else begin
							cmd.flush_start = 1'b1;
							state_d         = ST_RD;
						end
					end else if (sts.ovf) begin
						// rest of a rejected name is dropped
					end else if (sts.is_dot) begin
						cmd.flush_start = 1'b1;
						state_d         = ST_RD;
					end else if (sts.len_full) begin
						cmd.load_err = 1'b1;
						cmd.ovf_set  = 1'b1;
					end else begin
						cmd.store_wr = 1'b1;
					end
				end
			end
			ST_RD: begin
				cmd.k_inc = 1'b1;
				state_d   = ST_CAP_A;
			end
			ST_CAP_A: begin
				cmd.cap_first = 1'b1;
				if (sts.more) begin
					cmd.k_inc = 1'b1;
					state_d   = ST_CAP_B;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_CAP_B: begin
				cmd.cap_second = 1'b1;
				state_d        = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load_pair = 1'b1;
					if (sts.more) begin
						// next read overlaps the transfer of this pair
						cmd.k_inc = 1'b1;
						state_d   = ST_CAP_A;
					end else begin
						cmd.len_clr = 1'b1;
						state_d     = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/dns_name_label_encoder_unit.sv */
// sequence: a character is stored with no result; an error result is valid the cycle
// after its transfer; a dot or finish flushes via the read, capture and emit states,
// skipping the second capture for a single byte; throughput: one stored character per
// cycle while idle with the output free; a flush reads the single-port store once per
// byte and takes no new request until done; reset: arst_n clears length, overflow flag,
// sequencer and output valid; the label store is not cleared and needs no clearing pass
`timescale 1ns / 1ps
module dns_name_label_encoder_unit #(
	parameter int MAX_LABEL = 63
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  dnle_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output dnle_pkg::rsp_t rsp_data
);
	import dnle_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	dnle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dnle_datapath #(
		.MAX_LABEL (MAX_LABEL)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data)
	);

endmodule
